// ===== hw/rtl/cpu_6502_subset_execute_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the 6502 subset execute core
// Concurrent checks on posedge clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CPU_6502_SUBSET_EXECUTE_CORE_MACROS_SVH
`define CPU_6502_SUBSET_EXECUTE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CSE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CSE_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define CSE_ASSERT(lbl, prop, msg)
`define CSE_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== hw/rtl/cse_pkg.sv =====
// ----------------------------------------------------------------------------
// cse_pkg
// Opcodes, status codes, flag layout and shared types of the execute core.
// ----------------------------------------------------------------------------
package cse_pkg;

	localparam int MemAddrBitsDefault = 16;
	localparam logic [15:0] StackPage = 16'h0100;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_ILLEGAL = 2'd1,
		ST_HOST    = 2'd2
	} status_t;

	// stored flags: N V D I Z C
	localparam int FlN = 5;
	localparam int FlV = 4;
	localparam int FlD = 3;
	localparam int FlI = 2;
	localparam int FlZ = 1;
	localparam int FlC = 0;

	localparam logic [7:0] OP_ORA_IMM = 8'h09;
	localparam logic [7:0] OP_ORA_ABS = 8'h0D;
	localparam logic [7:0] OP_AND_ZP  = 8'h25;
	localparam logic [7:0] OP_AND_IMM = 8'h29;
	localparam logic [7:0] OP_AND_ABS = 8'h2D;
	localparam logic [7:0] OP_ASL_A   = 8'h0A;
	localparam logic [7:0] OP_ASL_ABS = 8'h0E;
	localparam logic [7:0] OP_ADC_ABS = 8'h6D;
	localparam logic [7:0] OP_INC_ZP  = 8'hE6;
	localparam logic [7:0] OP_INC_ABS = 8'hEE;
	localparam logic [7:0] OP_DEC_ABS = 8'hCE;
	localparam logic [7:0] OP_LDA_IMM = 8'hA9;
	localparam logic [7:0] OP_LDX_IMM = 8'hA2;
	localparam logic [7:0] OP_LDY_IMM = 8'hA0;
	localparam logic [7:0] OP_STA_ZP  = 8'h85;
	localparam logic [7:0] OP_STY_ZP  = 8'h84;
	localparam logic [7:0] OP_STA_ABS = 8'h8D;
	localparam logic [7:0] OP_STX_ABS = 8'h8E;
	localparam logic [7:0] OP_STY_ABS = 8'h8C;
	localparam logic [7:0] OP_STA_ABX = 8'h9D;
	localparam logic [7:0] OP_STA_ABY = 8'h99;
	localparam logic [7:0] OP_TAX     = 8'hAA;
	localparam logic [7:0] OP_TAY     = 8'hA8;
	localparam logic [7:0] OP_TXA     = 8'h8A;
	localparam logic [7:0] OP_TYA     = 8'h98;
	localparam logic [7:0] OP_INX     = 8'hE8;
	localparam logic [7:0] OP_INY     = 8'hC8;
	localparam logic [7:0] OP_DEX     = 8'hCA;
	localparam logic [7:0] OP_DEY     = 8'h88;
	localparam logic [7:0] OP_PHA     = 8'h48;
	localparam logic [7:0] OP_CLC     = 8'h18;
	localparam logic [7:0] OP_SEC     = 8'h38;
	localparam logic [7:0] OP_SEI     = 8'h78;
	localparam logic [7:0] OP_CLD     = 8'hD8;
	localparam logic [7:0] OP_SED     = 8'hF8;
	localparam logic [7:0] OP_NOP     = 8'hEA;
	localparam logic [7:0] OP_HOST    = 8'h80;

	// architectural register file
	typedef struct packed {
		logic [7:0]  a;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [7:0]  sp;
		logic [5:0]  fl;
		logic [15:0] pc;
	} arch_t;

	// execute result: new registers plus memory write
	typedef struct packed {
		arch_t       regs;
		status_t     status;
		logic        wr_valid;
		logic [15:0] wr_addr;
		logic [7:0]  wr_data;
	} exec_t;

	// zero-page operand addressing
	function automatic logic is_zp(input logic [7:0] op);
		return (op == OP_AND_ZP) || (op == OP_INC_ZP);
	endfunction

endpackage

// ===== hw/rtl/cse_if.sv =====
// ----------------------------------------------------------------------------
// cse_in_if / cse_out_if
// Valid/ready channels for instruction requests and execute results.
// ----------------------------------------------------------------------------
interface cse_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] opcode;
	logic [7:0] operand_low;
	logic [7:0] operand_high;

	modport source(output valid, opcode, operand_low, operand_high, input ready);
	modport sink(input valid, opcode, operand_low, operand_high, output ready);
endinterface

interface cse_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [7:0]  accumulator_out;
	logic [7:0]  index_x_out;
	logic [7:0]  index_y_out;
	logic [7:0]  stack_pointer_out;
	logic [7:0]  flags_out;
	logic [15:0] next_pc;
	logic        write_valid;
	logic [15:0] write_address;
	logic [7:0]  write_data;

	modport source(output valid, status, accumulator_out, index_x_out, index_y_out,
		stack_pointer_out, flags_out, next_pc, write_valid, write_address, write_data,
		input ready);
	modport sink(input valid, status, accumulator_out, index_x_out, index_y_out,
		stack_pointer_out, flags_out, next_pc, write_valid, write_address, write_data,
		output ready);
endinterface

// ===== hw/rtl/cse_dmem.sv =====
// ----------------------------------------------------------------------------
// cse_dmem
// Data memory: one sync read port, one write port, zeroing sweep after reset.
// ----------------------------------------------------------------------------
module cse_dmem import cse_pkg::*; #(
	parameter int MEM_ADDR_BITS = MemAddrBitsDefault
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [MEM_ADDR_BITS-1:0] rd_addr,
	output logic [7:0]               rd_data,
	input  logic                     wr_en,
	input  logic [MEM_ADDR_BITS-1:0] wr_addr,
	input  logic [7:0]               wr_data,
	output logic                     busy
);

	logic [7:0]               mem [2**MEM_ADDR_BITS];
	logic [MEM_ADDR_BITS-1:0] clr_addr_q;
	logic                     clr_busy_q;
	logic                     we_m;
	logic [MEM_ADDR_BITS-1:0] wa_m;
	logic [7:0]               wd_m;

	// clearing sweep owns the write port while busy
	always_comb begin
		we_m = clr_busy_q | wr_en;
		wa_m = clr_busy_q ? clr_addr_q : wr_addr;
		wd_m = clr_busy_q ? 8'h00 : wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (&clr_addr_q) clr_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (we_m) mem[wa_m] <= wd_m;
	end

	// read returns old contents on a same-cycle write
	always_ff @(posedge clk) begin
		if (rd_en) rd_data <= mem[rd_addr];
	end

	assign busy = clr_busy_q;

endmodule

// ===== hw/rtl/cse_alu.sv =====
// ----------------------------------------------------------------------------
// cse_alu
// Decode and execute of one instruction against registers and memory byte.
// ----------------------------------------------------------------------------
module cse_alu import cse_pkg::*; (
	input  logic [7:0] opcode,
	input  logic [7:0] lo,
	input  logic [7:0] hi,
	input  logic [7:0] mdata,
	input  arch_t      cur,
	output exec_t      res
);

	logic [15:0] abs_a;
	logic [8:0]  sum9;
	logic [7:0]  v;
	logic        set_v;
	logic        upd_nz;
	logic [1:0]  len;

	always_comb begin
		abs_a = {hi, lo};
		sum9 = {1'b0, cur.a} + {1'b0, mdata} + {8'h00, cur.fl[FlC]};
		res = '0;
		res.regs = cur;
		res.status = ST_OK;
		v = 8'h00;
		set_v = 1'b0;
		upd_nz = 1'b1;
		len = 2'd1;
		case (opcode)
			OP_ORA_IMM: begin res.regs.a = cur.a | lo; v = res.regs.a; len = 2'd2; end
			OP_ORA_ABS: begin res.regs.a = cur.a | mdata; v = res.regs.a; len = 2'd3; end
			OP_AND_ZP:  begin res.regs.a = cur.a & mdata; v = res.regs.a; len = 2'd2; end
			OP_AND_IMM: begin res.regs.a = cur.a & lo; v = res.regs.a; len = 2'd2; end
			OP_AND_ABS: begin res.regs.a = cur.a & mdata; v = res.regs.a; len = 2'd3; end
			OP_ASL_A: begin
				res.regs.fl[FlC] = cur.a[7];
				res.regs.a = {cur.a[6:0], 1'b0};
				v = res.regs.a;
			end
			OP_ASL_ABS: begin
				res.regs.fl[FlC] = mdata[7];
				v = {mdata[6:0], 1'b0};
				res.wr_valid = 1'b1; res.wr_addr = abs_a; res.wr_data = v; len = 2'd3;
			end
			OP_ADC_ABS: begin
				res.regs.fl[FlC] = sum9[8];
				set_v = 1'b1;
				res.regs.a = sum9[7:0];
				v = sum9[7:0];
				len = 2'd3;
			end
			OP_INC_ZP: begin
				v = mdata + 8'h01;
				res.wr_valid = 1'b1; res.wr_addr = {8'h00, lo}; res.wr_data = v; len = 2'd2;
			end
			OP_INC_ABS: begin
				v = mdata + 8'h01;
				res.wr_valid = 1'b1; res.wr_addr = abs_a; res.wr_data = v; len = 2'd3;
			end
			OP_DEC_ABS: begin
				v = mdata - 8'h01;
				res.wr_valid = 1'b1; res.wr_addr = abs_a; res.wr_data = v; len = 2'd3;
			end
			OP_LDA_IMM: begin res.regs.a = lo; v = lo; len = 2'd2; end
			OP_LDX_IMM: begin res.regs.x = lo; v = lo; len = 2'd2; end
			OP_LDY_IMM: begin res.regs.y = lo; v = lo; len = 2'd2; end
			OP_STA_ZP: begin
				upd_nz = 1'b0; len = 2'd2;
				res.wr_valid = 1'b1; res.wr_addr = {8'h00, lo}; res.wr_data = cur.a;
			end
			OP_STY_ZP: begin
				upd_nz = 1'b0; len = 2'd2;
				res.wr_valid = 1'b1; res.wr_addr = {8'h00, lo}; res.wr_data = cur.y;
			end
			OP_STA_ABS: begin
				upd_nz = 1'b0; len = 2'd3;
				res.wr_valid = 1'b1; res.wr_addr = abs_a; res.wr_data = cur.a;
			end
			OP_STX_ABS: begin
				upd_nz = 1'b0; len = 2'd3;
				res.wr_valid = 1'b1; res.wr_addr = abs_a; res.wr_data = cur.x;
			end
			OP_STY_ABS: begin
				upd_nz = 1'b0; len = 2'd3;
				res.wr_valid = 1'b1; res.wr_addr = abs_a; res.wr_data = cur.y;
			end
			OP_STA_ABX: begin
				upd_nz = 1'b0; len = 2'd3;
				res.wr_valid = 1'b1; res.wr_addr = abs_a + {8'h00, cur.x}; res.wr_data = cur.a;
			end
			OP_STA_ABY: begin
				upd_nz = 1'b0; len = 2'd3;
				res.wr_valid = 1'b1; res.wr_addr = abs_a + {8'h00, cur.y}; res.wr_data = cur.a;
			end
			OP_TAX: begin res.regs.x = cur.a; v = cur.a; end
			OP_TAY: begin res.regs.y = cur.a; v = cur.a; end
			OP_TXA: begin res.regs.a = cur.x; v = cur.x; end
			OP_TYA: begin res.regs.a = cur.y; v = cur.y; end
			OP_INX: begin res.regs.x = cur.x + 8'h01; v = res.regs.x; end
			OP_INY: begin res.regs.y = cur.y + 8'h01; v = res.regs.y; end
			OP_DEX: begin res.regs.x = cur.x - 8'h01; v = res.regs.x; end
			OP_DEY: begin res.regs.y = cur.y - 8'h01; v = res.regs.y; end
			OP_PHA: begin
				upd_nz = 1'b0;
				res.wr_valid = 1'b1; res.wr_addr = StackPage | {8'h00, cur.sp};
				res.wr_data = cur.a;
				res.regs.sp = cur.sp - 8'h01;
			end
			OP_CLC: begin upd_nz = 1'b0; res.regs.fl[FlC] = 1'b0; end
			OP_SEC: begin upd_nz = 1'b0; res.regs.fl[FlC] = 1'b1; end
			OP_SEI: begin upd_nz = 1'b0; res.regs.fl[FlI] = 1'b1; end
			OP_CLD: begin upd_nz = 1'b0; res.regs.fl[FlD] = 1'b0; end
			OP_SED: begin upd_nz = 1'b0; res.regs.fl[FlD] = 1'b1; end
			OP_NOP: upd_nz = 1'b0;
			OP_HOST: begin upd_nz = 1'b0; res.status = ST_HOST; len = 2'd2; end
			default: begin upd_nz = 1'b0; res.status = ST_ILLEGAL; len = 2'd0; end
		endcase
		// overflow: operands agree in sign, result differs
		if (set_v) res.regs.fl[FlV] = ~(cur.a[7] ^ mdata[7]) & (cur.a[7] ^ sum9[7]);
		if (upd_nz) begin
			res.regs.fl[FlN] = v[7];
			res.regs.fl[FlZ] = (v == 8'h00);
		end
		res.regs.pc = cur.pc + {14'd0, len};
	end

endmodule

// ===== hw/rtl/cpu_6502_subset_execute_core.sv =====
// ----------------------------------------------------------------------------
// cpu_6502_subset_execute_core
// Executes one 6502-subset instruction per request against registers and
// an internal zero-cleared data memory.
// ----------------------------------------------------------------------------
//  channel        | dir | handshake        | payload
//  instr          | in  | valid/ready      | opcode, operand_low, operand_high
//  result         | out | valid/ready      | status, registers, flags, pc, write
//  start_address  | in  | start_address_we | 16-bit pc load value
//
// One request per cycle sustained unless the result stalls; stages are memory
// read, then execute into the output register. Memory reads are forwarded
// from a write by the instruction one ahead. After reset the memory is zeroed,
// one byte a cycle over all 2**MEM_ADDR_BITS addresses, with instr.ready low.
// A stalled result holds the pipeline; one request waits in the read stage.
// ----------------------------------------------------------------------------
`include "cpu_6502_subset_execute_core_macros.svh"
module cpu_6502_subset_execute_core import cse_pkg::*; #(
	parameter int MEM_ADDR_BITS = MemAddrBitsDefault
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start_address_we,
	input  logic [15:0]     start_address,
	cse_in_if.sink          instr,
	cse_out_if.source       result
);

	localparam int AW = MEM_ADDR_BITS;

	logic          valid_s1;
	logic [7:0]    op_s1;
	logic [7:0]    lo_s1;
	logic [7:0]    hi_s1;
	logic          fwd_s1;
	logic [7:0]    fwd_data_s1;
	logic          out_valid_q;
	exec_t         out_q;
	arch_t         arch_q;
	exec_t         ex;
	logic          advance;
	logic          exec_fire;
	logic          accept;
	logic          clr_busy;
	logic [7:0]    rd_data;
	logic [7:0]    mdata;
	logic [15:0]   rd_addr16;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] ex_waddr;

	// handshake and pipeline advance
	assign advance   = !out_valid_q || result.ready;
	assign exec_fire = valid_s1 && advance;
	assign instr.ready = !clr_busy && (!valid_s1 || advance);
	assign accept    = instr.valid && instr.ready;

	// read address of the incoming request
	assign rd_addr16 = is_zp(instr.opcode) ? {8'h00, instr.operand_low}
		: {instr.operand_high, instr.operand_low};
	assign rd_addr  = rd_addr16[AW-1:0];
	assign ex_waddr = ex.wr_addr[AW-1:0];

	cse_dmem #(.MEM_ADDR_BITS(AW)) u_dmem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (exec_fire && ex.wr_valid),
		.wr_addr (ex_waddr),
		.wr_data (ex.wr_data),
		.busy    (clr_busy)
	);

	assign mdata = fwd_s1 ? fwd_data_s1 : rd_data;

	cse_alu u_alu (
		.opcode (op_s1),
		.lo     (lo_s1),
		.hi     (hi_s1),
		.mdata  (mdata),
		.cur    (arch_q),
		.res    (ex)
	);

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (exec_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= instr.opcode;
			lo_s1       <= instr.operand_low;
			hi_s1       <= instr.operand_high;
			fwd_s1      <= exec_fire && ex.wr_valid && (ex_waddr == rd_addr);
			fwd_data_s1 <= ex.wr_data;
		end
	end

	// architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arch_q <= '{a: 8'h00, x: 8'h00, y: 8'h00, sp: 8'hFF, fl: 6'd0, pc: 16'h0000};
		end else if (start_address_we) begin
			arch_q.pc <= start_address;
		end else if (exec_fire) begin
			arch_q <= ex.regs;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) out_q <= ex;
	end

	assign result.valid             = out_valid_q;
	assign result.status            = out_q.status;
	assign result.accumulator_out   = out_q.regs.a;
	assign result.index_x_out       = out_q.regs.x;
	assign result.index_y_out       = out_q.regs.y;
	assign result.stack_pointer_out = out_q.regs.sp;
	assign result.flags_out         = {out_q.regs.fl[FlN], out_q.regs.fl[FlV], 1'b1, 1'b0,
		out_q.regs.fl[FlD], out_q.regs.fl[FlI], out_q.regs.fl[FlZ], out_q.regs.fl[FlC]};
	assign result.next_pc           = out_q.regs.pc;
	assign result.write_valid       = out_q.wr_valid;
	assign result.write_address     = out_q.wr_addr;
	assign result.write_data        = out_q.wr_data;

	// checks
	`CSE_ASSERT(a_no_req_clr, (clr_busy |-> !instr.ready), "request taken during memory clear")
	`CSE_ASSERT(a_no_exec_clr, (clr_busy |-> !valid_s1), "execute during memory clear")
	`CSE_ASSERT_NEXT(a_s1_hold, (valid_s1 && !advance), valid_s1, "stalled request dropped")
	`CSE_ASSERT(a_illegal_nowr,
		((out_valid_q && out_q.status == ST_ILLEGAL) |-> !out_q.wr_valid),
		"illegal opcode wrote memory")

endmodule

// ===== verif/cpu_6502_subset_execute_core_tb.sv =====
// ----------------------------------------------------------------------------
// cpu_6502_subset_execute_core_tb
// Self-checking bench for the 6502 subset execute core. A directed table
// covers every opcode, PC wrap, indexed address wrap, illegal and host call.
// Random instruction streams follow in four handshake phases, with a new
// start address between phases. Every result is checked field by field
// against a behavioral model of the registers, flags and data memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module cpu_6502_subset_execute_core_tb;
	import cse_pkg::*;

	localparam int CycleLimit = 2000000;
	// packed flag byte positions
	localparam int PN = 7, PV = 6, PD = 3, PI = 2, PZ = 1, PC = 0;

	typedef struct {
		status_t     status;
		logic [7:0]  a, x, y, sp, fl;
		logic [15:0] pc;
		logic        wv;
		logic [15:0] wa;
		logic [7:0]  wd;
	} exec_res_t;

	typedef struct {
		logic [7:0]  op, lo, hi;
		bit          typed;
		status_t     st;
		logic [15:0] pc;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start_address_we = 1'b0;
	logic [15:0] start_address = '0;
	int cycles = 0;
	int errors = 0;
	int snd_pct = 0;
	int rcv_pct = 0;

	cse_in_if instr();
	cse_out_if result();

	cpu_6502_subset_execute_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.start_address_we(start_address_we),
		.start_address(start_address),
		.instr(instr.sink),
		.result(result.source)
	);

	// machine state mirror
	logic [7:0]  m_a, m_x, m_y, m_sp, m_fl;
	logic [15:0] m_pc;
	logic [7:0]  m_mem [0:65535];
	exec_res_t   pending_q [$];
	dir_row_t    dir_tbl [$];

	logic [7:0] legal_ops [] = '{OP_ORA_IMM, OP_ORA_ABS, OP_AND_ZP, OP_AND_IMM, OP_AND_ABS,
		OP_ASL_A, OP_ASL_ABS, OP_ADC_ABS, OP_INC_ZP, OP_INC_ABS, OP_DEC_ABS, OP_LDA_IMM,
		OP_LDX_IMM, OP_LDY_IMM, OP_STA_ZP, OP_STY_ZP, OP_STA_ABS, OP_STX_ABS, OP_STY_ABS,
		OP_STA_ABX, OP_STA_ABY, OP_TAX, OP_TAY, OP_TXA, OP_TYA, OP_INX, OP_INY, OP_DEX,
		OP_DEY, OP_PHA, OP_CLC, OP_SEC, OP_SEI, OP_CLD, OP_SED, OP_NOP, OP_HOST};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void set_nz(input logic [7:0] v);
		m_fl[PZ] = (v == 8'h00);
		m_fl[PN] = v[7];
	endfunction

	function automatic void mem_store(input logic [15:0] addr, input logic [7:0] v,
			inout exec_res_t r);
		m_mem[addr] = v;
		r.wv = 1'b1;
		r.wa = addr;
		r.wd = v;
	endfunction

	// execute one instruction on the mirror state
	function automatic exec_res_t execute(input logic [7:0] op, lo, hi);
		exec_res_t r;
		logic [15:0] ab;
		logic [15:0] len;
		logic [8:0] sum;
		logic [7:0] m;
		ab = {hi, lo};
		len = 16'd1;
		r.status = ST_OK;
		r.wv = 1'b0;
		r.wa = '0;
		r.wd = '0;
		case (op)
			OP_ORA_IMM: begin m_a |= lo; set_nz(m_a); len = 2; end
			OP_ORA_ABS: begin m_a |= m_mem[ab]; set_nz(m_a); len = 3; end
			OP_AND_ZP: begin m_a &= m_mem[{8'h00, lo}]; set_nz(m_a); len = 2; end
			OP_AND_IMM: begin m_a &= lo; set_nz(m_a); len = 2; end
			OP_AND_ABS: begin m_a &= m_mem[ab]; set_nz(m_a); len = 3; end
			OP_ASL_A: begin m_fl[PC] = m_a[7]; m_a = m_a << 1; set_nz(m_a); end
			OP_ASL_ABS: begin
				m = m_mem[ab];
				m_fl[PC] = m[7];
				mem_store(ab, m << 1, r);
				set_nz(m << 1);
				len = 3;
			end
			OP_ADC_ABS: begin
				m = m_mem[ab];
				sum = m_a + m + m_fl[PC];
				m_fl[PC] = sum[8];
				m_fl[PV] = (m_a[7] == m[7]) && (sum[7] != m_a[7]);
				m_a = sum[7:0];
				set_nz(m_a);
				len = 3;
			end
			OP_INC_ZP: begin
				m = m_mem[{8'h00, lo}] + 8'd1;
				mem_store({8'h00, lo}, m, r); set_nz(m); len = 2;
			end
			OP_INC_ABS: begin m = m_mem[ab] + 8'd1; mem_store(ab, m, r); set_nz(m); len = 3; end
			OP_DEC_ABS: begin m = m_mem[ab] - 8'd1; mem_store(ab, m, r); set_nz(m); len = 3; end
			OP_LDA_IMM: begin m_a = lo; set_nz(lo); len = 2; end
			OP_LDX_IMM: begin m_x = lo; set_nz(lo); len = 2; end
			OP_LDY_IMM: begin m_y = lo; set_nz(lo); len = 2; end
			OP_STA_ZP: begin mem_store({8'h00, lo}, m_a, r); len = 2; end
			OP_STY_ZP: begin mem_store({8'h00, lo}, m_y, r); len = 2; end
			OP_STA_ABS: begin mem_store(ab, m_a, r); len = 3; end
			OP_STX_ABS: begin mem_store(ab, m_x, r); len = 3; end
			OP_STY_ABS: begin mem_store(ab, m_y, r); len = 3; end
			OP_STA_ABX: begin mem_store(ab + m_x, m_a, r); len = 3; end
			OP_STA_ABY: begin mem_store(ab + m_y, m_a, r); len = 3; end
			OP_TAX: begin m_x = m_a; set_nz(m_x); end
			OP_TAY: begin m_y = m_a; set_nz(m_y); end
			OP_TXA: begin m_a = m_x; set_nz(m_a); end
			OP_TYA: begin m_a = m_y; set_nz(m_a); end
			OP_INX: begin m_x++; set_nz(m_x); end
			OP_INY: begin m_y++; set_nz(m_y); end
			OP_DEX: begin m_x--; set_nz(m_x); end
			OP_DEY: begin m_y--; set_nz(m_y); end
			OP_PHA: begin mem_store(StackPage | m_sp, m_a, r); m_sp--; end
			OP_CLC: m_fl[PC] = 1'b0;
			OP_SEC: m_fl[PC] = 1'b1;
			OP_SEI: m_fl[PI] = 1'b1;
			OP_CLD: m_fl[PD] = 1'b0;
			OP_SED: m_fl[PD] = 1'b1;
			OP_NOP: ;
			OP_HOST: begin r.status = ST_HOST; len = 2; end
			default: begin r.status = ST_ILLEGAL; len = 0; end
		endcase
		m_pc += len;
		r.a = m_a;
		r.x = m_x;
		r.y = m_y;
		r.sp = m_sp;
		r.fl = m_fl | 8'h20;
		r.pc = m_pc;
		return r;
	endfunction

	// drive one request, honoring the sender idle rate
	task automatic send_instr(input logic [7:0] op, lo, hi, input bit typed = 0,
			input status_t st = ST_OK, input logic [15:0] pc = '0);
		exec_res_t r;
		while ($urandom_range(99) < snd_pct) begin
			instr.valid <= 1'b0;
			@(posedge clk);
		end
		instr.valid <= 1'b1;
		instr.opcode <= op;
		instr.operand_low <= lo;
		instr.operand_high <= hi;
		do @(posedge clk); while (!instr.ready);
		r = execute(op, lo, hi);
		if (typed) begin
			r.status = st;
			r.pc = pc;
		end
		pending_q.push_back(r);
	endtask

	// wait for the block to drain, then load a new start address
	task automatic load_start(input logic [15:0] v);
		instr.valid <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		start_address_we <= 1'b1;
		start_address <= v;
		@(posedge clk);
		start_address_we <= 1'b0;
		m_pc = v;
	endtask

	// address bytes biased toward a few pages so reads hit earlier writes
	function automatic logic [7:0] pick_hi();
		case ($urandom_range(3))
			0: return 8'h00;
			1: return 8'h01;
			2: return 8'hFF;
			default: return $urandom_range(255);
		endcase
	endfunction

	// result side: random stall and compare
	always @(posedge clk) begin
		exec_res_t e;
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("cpu_6502_subset_execute_core_tb: done, errors");
			$finish;
		end
		if (arst_n && result.valid && result.ready) begin
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result", $time);
				errors++;
			end else begin
				e = pending_q.pop_front();
				if (result.status !== e.status || result.accumulator_out !== e.a ||
						result.index_x_out !== e.x || result.index_y_out !== e.y ||
						result.stack_pointer_out !== e.sp || result.flags_out !== e.fl ||
						result.next_pc !== e.pc || result.write_valid !== e.wv ||
						result.write_address !== e.wa || result.write_data !== e.wd) begin
					$display("%0t: mismatch exp st=%0d a=%h x=%h y=%h sp=%h f=%h pc=%h w=%b %h %h",
						$time, e.status, e.a, e.x, e.y, e.sp, e.fl, e.pc, e.wv, e.wa, e.wd);
					$display("%0t:          got st=%0d a=%h x=%h y=%h sp=%h f=%h pc=%h w=%b %h %h",
						$time, result.status, result.accumulator_out, result.index_x_out,
						result.index_y_out, result.stack_pointer_out, result.flags_out,
						result.next_pc, result.write_valid, result.write_address,
						result.write_data);
					errors++;
				end
			end
		end
		result.ready <= ($urandom_range(99) >= rcv_pct);
	end

	initial begin
		int snd_tab [4] = '{0, 53, 0, 24};
		int rcv_tab [4] = '{0, 0, 53, 24};
		logic [15:0] starts [4] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0000};
		logic [7:0] op;
		instr.valid = 1'b0;
		instr.opcode = '0;
		instr.operand_low = '0;
		instr.operand_high = '0;
		result.ready = 1'b0;
		m_a = '0; m_x = '0; m_y = '0; m_sp = 8'hFF; m_fl = '0; m_pc = '0;
		foreach (m_mem[i]) m_mem[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: PC near top to show wrap, then every operation
		load_start(16'hFFFE);
		dir_tbl.push_back('{8'h02, 8'h00, 8'h00, 1, ST_ILLEGAL, 16'hFFFE});
		dir_tbl.push_back('{OP_NOP, 8'hFF, 8'hFF, 1, ST_OK, 16'hFFFF});
		dir_tbl.push_back('{OP_LDA_IMM, 8'hFF, 8'h00, 1, ST_OK, 16'h0001});
		dir_tbl.push_back('{OP_HOST, 8'hFF, 8'hFF, 1, ST_HOST, 16'h0003});
		dir_tbl.push_back('{8'hFF, 8'hFF, 8'hFF, 1, ST_ILLEGAL, 16'h0003});
		dir_tbl.push_back('{OP_ASL_A, 8'h00, 8'h00, 0, ST_OK, 0});
		dir_tbl.push_back('{OP_ADC_ABS, 8'hFF, 8'hFF, 0, ST_OK, 0});
		dir_tbl.push_back('{OP_STA_ABS, 8'hFF, 8'hFF, 0, ST_OK, 0});
		dir_tbl.push_back('{OP_LDX_IMM, 8'h80, 8'h00, 0, ST_OK, 0});
		dir_tbl.push_back('{OP_LDY_IMM, 8'h00, 8'h00, 0, ST_OK, 0});
		dir_tbl.push_back('{OP_STA_ABX, 8'hF0, 8'hFF, 0, ST_OK, 0});
		dir_tbl.push_back('{OP_STA_ABY, 8'h34, 8'h12, 0, ST_OK, 0});
		dir_tbl.push_back('{OP_STX_ABS, 8'hFF, 8'h00, 0, ST_OK, 0});
		dir_tbl.push_back('{OP_STY_ZP, 8'hFF, 8'h00, 0, ST_OK, 0});
		dir_tbl.push_back('{OP_STY_ABS, 8'h00, 8'h00, 0, ST_OK, 0});
		dir_tbl.push_back('{OP_STA_ZP, 8'h00, 8'h00, 0, ST_OK, 0});
		dir_tbl.push_back('{OP_ORA_IMM, 8'h55, 8'h00, 0, ST_OK, 0});
		dir_tbl.push_back('{OP_ORA_ABS, 8'hFF, 8'hFF, 0, ST_OK, 0});
		dir_tbl.push_back('{OP_AND_IMM, 8'hF0, 8'h00, 0, ST_OK, 0});
		dir_tbl.push_back('{OP_AND_ZP, 8'h00, 8'h00, 0, ST_OK, 0});
		dir_tbl.push_back('{OP_AND_ABS, 8'h70, 8'h00, 0, ST_OK, 0});
		dir_tbl.push_back('{OP_ASL_ABS, 8'hFF, 8'hFF, 0, ST_OK, 0});
		dir_tbl.push_back('{OP_INC_ZP, 8'hFF, 8'h00, 0, ST_OK, 0});
		dir_tbl.push_back('{OP_INC_ABS, 8'h00, 8'h00, 0, ST_OK, 0});
		dir_tbl.push_back('{OP_DEC_ABS, 8'hFF, 8'h00, 0, ST_OK, 0});
		dir_tbl.push_back('{OP_SEC, 8'h00, 8'h00, 0, ST_OK, 0});
		dir_tbl.push_back('{OP_SED, 8'h00, 8'h00, 0, ST_OK, 0});
		dir_tbl.push_back('{OP_SEI, 8'h00, 8'h00, 0, ST_OK, 0});
		dir_tbl.push_back('{OP_CLD, 8'h00, 8'h00, 0, ST_OK, 0});
		dir_tbl.push_back('{OP_CLC, 8'h00, 8'h00, 0, ST_OK, 0});
		dir_tbl.push_back('{OP_TAX, 8'h00, 8'h00, 0, ST_OK, 0});
		dir_tbl.push_back('{OP_TAY, 8'h00, 8'h00, 0, ST_OK, 0});
		dir_tbl.push_back('{OP_DEX, 8'h00, 8'h00, 0, ST_OK, 0});
		dir_tbl.push_back('{OP_DEY, 8'h00, 8'h00, 0, ST_OK, 0});
		dir_tbl.push_back('{OP_TXA, 8'h00, 8'h00, 0, ST_OK, 0});
		dir_tbl.push_back('{OP_TYA, 8'h00, 8'h00, 0, ST_OK, 0});
		dir_tbl.push_back('{OP_INX, 8'h00, 8'h00, 0, ST_OK, 0});
		dir_tbl.push_back('{OP_INY, 8'h00, 8'h00, 0, ST_OK, 0});
		dir_tbl.push_back('{OP_PHA, 8'h00, 8'h00, 0, ST_OK, 0});
		foreach (dir_tbl[i])
			send_instr(dir_tbl[i].op, dir_tbl[i].lo, dir_tbl[i].hi, dir_tbl[i].typed,
				dir_tbl[i].st, dir_tbl[i].pc);

		// random phases, one idling mode each
		for (int p = 0; p < 4; p++) begin
			load_start(p == 2 ? 16'($urandom_range(16'hFFFF)) : starts[p]);
			snd_pct = snd_tab[p];
			rcv_pct = rcv_tab[p];
			// stack pointer wraps once through the full page
			if (p == 1)
				for (int k = 0; k < 260; k++)
					send_instr(OP_PHA, $urandom_range(255), $urandom_range(255));
			for (int k = 0; k < 390; k++) begin
				if ($urandom_range(9) == 0)
					op = $urandom_range(255);
				else
					op = legal_ops[$urandom_range(legal_ops.size() - 1)];
				send_instr(op, $urandom_range(255), pick_hi());
			end
		end

		instr.valid <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("cpu_6502_subset_execute_core_tb: done, clean");
		else
			$display("cpu_6502_subset_execute_core_tb: done, errors");
		$finish;
	end

endmodule
